@@ src/lobs_pkg.sv @@
// Shared types, constants and coefficient functions for the Luenberger observer step.
// Holds the base coefficient tables and the fixed-point conversion used at elaboration.
// No dependencies.
package lobs_pkg;

	localparam int IDX_W = 4;
	localparam int ACC_W = 68;
	localparam int OUT_N = 6;
	localparam int BASE_N = 6;
	localparam int BASE_M = 2;

	localparam logic [95:0] DEC_ONE = 96'd10000000000;
	localparam longint BASE_SCALE = 64'sd71500000000;

	localparam longint BASE_A [BASE_N][BASE_N] = '{
		'{64'sd6689870000, 64'sd0, 64'sd4370010000, 64'sd0, 64'sd0, 64'sd0},
		'{64'sd0, 64'sd7119520000, 64'sd0, 64'sd6253290000, 64'sd0, 64'sd0},
		'{64'sd0, 64'sd0, 64'sd4551890000, 64'sd0, 64'sd0, 64'sd0},
		'{64'sd0, 64'sd0, 64'sd0, 64'sd2320650000, 64'sd0, 64'sd0},
		'{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd10000000000, 64'sd0},
		'{64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd10000000000}
	};
	localparam longint BASE_B [BASE_N][BASE_M] = '{
		'{64'sd5603500000, 64'sd1026587000},
		'{64'sd1606720000, 64'sd5769560000},
		'{64'sd0, 64'sd2649723000},
		'{64'sd2012360000, 64'sd0},
		'{64'sd0, 64'sd0},
		'{64'sd0, 64'sd0}
	};
	localparam longint BASE_L [BASE_N][BASE_M] = '{
		'{-64'sd86550000, 64'sd0},
		'{64'sd0, -64'sd630836400},
		'{-64'sd7020000, 64'sd0},
		'{64'sd0, -64'sd8309694},
		'{64'sd7763130000, 64'sd0},
		'{64'sd0, 64'sd14240400000}
	};
	localparam longint BASE_C [BASE_M][BASE_N] = '{
		'{64'sd60240960000, 64'sd0, 64'sd0, 64'sd0, 64'sd10000000000, 64'sd0},
		'{64'sd0, 64'sd60240960000, 64'sd0, 64'sd0, 64'sd0, 64'sd10000000000}
	};

	typedef enum logic [2:0] {
		OP_Y,
		OP_C,
		OP_A,
		OP_B,
		OP_L
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN_Y,
		ST_RUN_C,
		ST_RUN_A,
		ST_RUN_B,
		ST_RUN_L,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic             issue;
		op_t              op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             first;
		logic             last;
		logic             load_in;
		logic             commit;
	} cmd_t;

	// decimal value in units of 1e-10 to signed fixed point, round half away from zero
	function automatic logic signed [31:0] to_fixed(input longint dec, input int frac);
		logic [95:0] m;
		logic [95:0] q;
		logic [95:0] r;
		logic [95:0] res;
		m = (dec < 0) ? 96'(-dec) : 96'(dec);
		q = m / DEC_ONE;
		r = m % DEC_ONE;
		res = (q << frac) + (((r << frac) + DEC_ONE / 2) / DEC_ONE);
		if (res > 96'h7FFF_FFFF) begin
			res = 96'h7FFF_FFFF + ((dec < 0) ? 96'd1 : 96'd0);
		end
		return (dec < 0) ? 32'(-res) : 32'(res);
	endfunction

	function automatic logic signed [31:0] coef_a_val(input int i, input int k, input int frac);
		logic signed [31:0] v;
		v = '0;
		if (i < BASE_N && k < BASE_N) begin
			v = to_fixed(BASE_A[i][k], frac);
		end
		return v;
	endfunction

	function automatic logic signed [31:0] coef_b_val(input int i, input int k, input int frac);
		logic signed [31:0] v;
		v = '0;
		if (i < BASE_N && k < BASE_M) begin
			v = to_fixed(BASE_B[i][k], frac);
		end
		return v;
	endfunction

	function automatic logic signed [31:0] coef_l_val(input int i, input int k, input int frac);
		logic signed [31:0] v;
		v = '0;
		if (i < BASE_N && k < BASE_M) begin
			v = to_fixed(BASE_L[i][k], frac);
		end
		return v;
	endfunction

	function automatic logic signed [31:0] coef_c_val(input int k, input int i, input int frac);
		logic signed [31:0] v;
		v = '0;
		if (i < BASE_N && k < BASE_M) begin
			v = to_fixed(BASE_C[k][i], frac);
		end
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
			r = v[31:0];
		end else if (v[ACC_W-1]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

@@ src/lobs_ctrl.sv @@
// Sequencer for the observer step: walks the products of each update through the shared MAC.
// Depends on lobs_pkg (state_t, op_t, cmd_t).
module lobs_ctrl
	import lobs_pkg::*;
#(
	parameter int STATE_DIM = 6,
	parameter int IO_DIM = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [IDX_W-1:0] row_q, row_d;
	logic [IDX_W-1:0] col_q, col_d;
	logic out_valid_q;
	logic col_last_s, col_last_i, row_last_s, row_last_i;
	logic slot_free;

	assign col_last_s = (col_q == IDX_W'(STATE_DIM - 1));
	assign col_last_i = (col_q == IDX_W'(IO_DIM - 1));
	assign row_last_s = (row_q == IDX_W'(STATE_DIM - 1));
	assign row_last_i = (row_q == IDX_W'(IO_DIM - 1));
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q <= row_d;
			col_q <= col_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		row_d = row_q;
		col_d = col_q;
		unique case (state_q)
			ST_IDLE: begin
				row_d = '0;
				col_d = '0;
				if (in_valid) begin
					state_d = ST_RUN_Y;
				end
			end
			ST_RUN_Y: begin
				if (row_last_i) begin
					row_d = '0;
					state_d = ST_RUN_C;
				end else begin
					row_d = row_q + 1'b1;
				end
			end
			ST_RUN_C: begin
				if (col_last_s) begin
					col_d = '0;
					if (row_last_i) begin
						row_d = '0;
						state_d = ST_RUN_A;
					end else begin
						row_d = row_q + 1'b1;
					end
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			ST_RUN_A: begin
				if (col_last_s) begin
					col_d = '0;
					state_d = ST_RUN_B;
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			ST_RUN_B: begin
				if (col_last_i) begin
					col_d = '0;
					state_d = ST_RUN_L;
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			ST_RUN_L: begin
				if (col_last_i) begin
					col_d = '0;
					if (row_last_s) begin
						state_d = ST_DRAIN;
					end else begin
						row_d = row_q + 1'b1;
						state_d = ST_RUN_A;
					end
				end else begin
					col_d = col_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = OP_Y;
		cmd.row = row_q;
		cmd.col = col_q;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
			end
			ST_RUN_Y: begin
				cmd.issue = 1'b1;
				cmd.op = OP_Y;
				cmd.col = row_q;
				cmd.first = 1'b1;
				cmd.last = 1'b1;
			end
			ST_RUN_C: begin
				cmd.issue = 1'b1;
				cmd.op = OP_C;
				cmd.first = (col_q == '0);
				cmd.last = col_last_s;
			end
			ST_RUN_A: begin
				cmd.issue = 1'b1;
				cmd.op = OP_A;
				cmd.first = (col_q == '0);
				cmd.last = col_last_s;
			end
			ST_RUN_B: begin
				cmd.issue = 1'b1;
				cmd.op = OP_B;
				cmd.first = (col_q == '0);
				cmd.last = col_last_i;
			end
			ST_RUN_L: begin
				cmd.issue = 1'b1;
				cmd.op = OP_L;
				cmd.first = (col_q == '0);
				cmd.last = col_last_i;
			end
			ST_DRAIN: begin
			end
			ST_COMMIT: begin
				cmd.commit = slot_free;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/lobs_dp.sv @@
// Datapath for the observer step: coefficient tables, shared 32x32 MAC, vector registers.
// Depends on lobs_pkg (cmd_t, op_t, coefficient functions, sat32); driven by lobs_ctrl.
module lobs_dp
	import lobs_pkg::*;
#(
	parameter int STATE_DIM = 6,
	parameter int IO_DIM = 2,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic               cfg_write_en,
	input  logic [30:0]        cfg_write_data,
	input  logic signed [31:0] reading_first,
	input  logic signed [31:0] reading_second,
	input  logic signed [31:0] drive_first,
	input  logic signed [31:0] drive_second,
	output logic signed [31:0] est_pad [OUT_N]
);

	localparam int SW = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
	localparam int IW = (IO_DIM > 1) ? $clog2(IO_DIM) : 1;
	localparam logic [30:0] SCALE_RST = 31'(to_fixed(BASE_SCALE, FRAC_BITS));

	logic signed [31:0] coef_a [STATE_DIM][STATE_DIM];
	logic signed [31:0] coef_b [STATE_DIM][IO_DIM];
	logic signed [31:0] coef_l [STATE_DIM][IO_DIM];
	logic signed [31:0] coef_c [IO_DIM][STATE_DIM];

	logic [30:0] scale_q;
	logic signed [31:0] estimate_q [STATE_DIM];
	logic signed [31:0] next_q [STATE_DIM];
	logic signed [31:0] rd_in [IO_DIM];
	logic signed [31:0] u_in [IO_DIM];
	logic signed [31:0] rd_q [IO_DIM];
	logic signed [31:0] u_q [IO_DIM];
	logic signed [31:0] y_q [IO_DIM];
	logic signed [31:0] c1_q [IO_DIM];
	logic signed [31:0] a1_q;
	logic signed [31:0] a2_q;
	logic signed [ACC_W-1:0] acc_q;

	logic [SW-1:0] s_row, s_col, s_row_s1;
	logic [IW-1:0] i_row, i_col, i_row_s1;
	logic signed [31:0] op_a, op_b;

	logic               valid_s1;
	op_t                op_s1;
	logic [IDX_W-1:0]   row_s1;
	logic               first_s1;
	logic               last_s1;
	logic signed [63:0] prod_s1;

	logic signed [63:0] prod_sh;
	logic signed [ACC_W-1:0] sum;
	logic signed [31:0] dot_sat;

	for (genvar gi = 0; gi < STATE_DIM; gi++) begin : g_row
		for (genvar gk = 0; gk < STATE_DIM; gk++) begin : g_a
			localparam logic signed [31:0] CA = coef_a_val(gi, gk, FRAC_BITS);
			assign coef_a[gi][gk] = CA;
		end
		for (genvar gk = 0; gk < IO_DIM; gk++) begin : g_io
			localparam logic signed [31:0] CB = coef_b_val(gi, gk, FRAC_BITS);
			localparam logic signed [31:0] CL = coef_l_val(gi, gk, FRAC_BITS);
			localparam logic signed [31:0] CC = coef_c_val(gk, gi, FRAC_BITS);
			assign coef_b[gi][gk] = CB;
			assign coef_l[gi][gk] = CL;
			assign coef_c[gk][gi] = CC;
		end
	end

	for (genvar gk = 0; gk < IO_DIM; gk++) begin : g_in
		if (gk == 0) begin : g_first
			assign rd_in[gk] = reading_first;
			assign u_in[gk] = drive_first;
		end else if (gk == 1) begin : g_second
			assign rd_in[gk] = reading_second;
			assign u_in[gk] = drive_second;
		end else begin : g_zero
			assign rd_in[gk] = '0;
			assign u_in[gk] = '0;
		end
	end

	for (genvar go = 0; go < OUT_N; go++) begin : g_out
		if (go < STATE_DIM) begin : g_used
			assign est_pad[go] = estimate_q[go];
		end else begin : g_pad
			assign est_pad[go] = '0;
		end
	end

	assign s_row = cmd.row[SW-1:0];
	assign s_col = cmd.col[SW-1:0];
	assign i_row = cmd.row[IW-1:0];
	assign i_col = cmd.col[IW-1:0];
	assign s_row_s1 = row_s1[SW-1:0];
	assign i_row_s1 = row_s1[IW-1:0];

	always_comb begin
		unique case (cmd.op)
			OP_Y: begin
				op_a = rd_q[i_col];
				op_b = $signed({1'b0, scale_q});
			end
			OP_C: begin
				op_a = coef_c[i_row][s_col];
				op_b = estimate_q[s_col];
			end
			OP_A: begin
				op_a = coef_a[s_row][s_col];
				op_b = estimate_q[s_col];
			end
			OP_B: begin
				op_a = coef_b[s_row][i_col];
				op_b = u_q[i_col];
			end
			OP_L: begin
				op_a = coef_l[s_row][i_col];
				op_b = c1_q[i_col];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			valid_s1 <= 1'b0;
			for (int i = 0; i < STATE_DIM; i++) begin
				estimate_q[i] <= '0;
			end
		end else begin
			if (cfg_write_en) begin
				scale_q <= cfg_write_data;
			end
			valid_s1 <= cmd.issue;
			if (cmd.commit) begin
				estimate_q <= next_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			rd_q <= rd_in;
			u_q <= u_in;
		end
		if (cmd.issue) begin
			op_s1 <= cmd.op;
			row_s1 <= cmd.row;
			first_s1 <= cmd.first;
			last_s1 <= cmd.last;
			prod_s1 <= op_a * op_b;
		end
	end

	// arithmetic shift floors the product
	assign prod_sh = prod_s1 >>> FRAC_BITS;
	assign sum = first_s1 ? ACC_W'(prod_sh) : acc_q + ACC_W'(prod_sh);
	assign dot_sat = sat32(sum);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= sum;
			if (last_s1) begin
				unique case (op_s1)
					OP_Y: y_q[i_row_s1] <= dot_sat;
					OP_C: c1_q[i_row_s1] <= sat32(ACC_W'(dot_sat) - ACC_W'(y_q[i_row_s1]));
					OP_A: a1_q <= dot_sat;
					OP_B: a2_q <= dot_sat;
					OP_L: next_q[s_row_s1] <= sat32(ACC_W'(a1_q) + ACC_W'(a2_q) - ACC_W'(dot_sat));
					default: begin
					end
				endcase
			end
		end
	end

endmodule

@@ src/luenberger_observer_step.sv @@
// Top level of the Luenberger observer step: controller plus MAC datapath.
// Depends on lobs_pkg, lobs_ctrl and lobs_dp.
//
// Usage:
//   Input channel (in_valid/in_stall) takes two sensor readings and two control
//   inputs per transaction. Output channel (out_valid/out_stall) returns the six
//   new state estimates, signed Q16.16, saturated.
//   cfg_write_en/cfg_write_data write the 31-bit measure_scale register; write
//   only while the block is idle.
// Timing:
//   One shared 32x32 multiplier does every product, one per cycle, followed by
//   one accumulate stage. An update runs the scaled readings, then the C rows,
//   then for each state row the A, B and L products, then drain and commit;
//   a new transaction is accepted in the cycle after the result is posted.
// Reset: estimate cleared to zero, measure_scale set to 7.15, both channels idle.
// Stall: the result is held on the outputs while out_stall is high. The next
//   transaction may be accepted and computed meanwhile; its result waits until
//   the previous one is taken.
module luenberger_observer_step
	import lobs_pkg::*;
#(
	parameter int STATE_DIM = 6,
	parameter int IO_DIM = 2,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] reading_first,
	input  logic signed [31:0] reading_second,
	input  logic signed [31:0] drive_first,
	input  logic signed [31:0] drive_second,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] est_zero,
	output logic signed [31:0] est_one,
	output logic signed [31:0] est_two,
	output logic signed [31:0] est_three,
	output logic signed [31:0] est_four,
	output logic signed [31:0] est_five,
	input  logic               cfg_write_en,
	input  logic [30:0]        cfg_write_data
);

	cmd_t cmd;
	logic signed [31:0] est_pad [OUT_N];

	lobs_ctrl #(
		.STATE_DIM(STATE_DIM),
		.IO_DIM(IO_DIM)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd)
	);

	lobs_dp #(
		.STATE_DIM(STATE_DIM),
		.IO_DIM(IO_DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.reading_first(reading_first),
		.reading_second(reading_second),
		.drive_first(drive_first),
		.drive_second(drive_second),
		.est_pad(est_pad)
	);

	assign est_zero = est_pad[0];
	assign est_one = est_pad[1];
	assign est_two = est_pad[2];
	assign est_three = est_pad[3];
	assign est_four = est_pad[4];
	assign est_five = est_pad[5];

endmodule

@@ verif/tb_top.sv @@
// Testbench for luenberger_observer_step: directed and random transactions checked against
// a local fixed-point observer model, under input/output idling and a long output hold-off.
// Depends on the luenberger_observer_step RTL and lobs_pkg.
`timescale 1ns / 1ps

module tb_top;

	localparam int FRAC = 16;
	localparam longint DEC_UNIT = 64'sd10000000000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_LEN = 700;
	localparam int TAIL_CYCLES = 100;

	typedef logic [5:0][31:0] est_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] reading_first = '0;
	logic signed [31:0] reading_second = '0;
	logic signed [31:0] drive_first = '0;
	logic signed [31:0] drive_second = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] est_zero;
	logic signed [31:0] est_one;
	logic signed [31:0] est_two;
	logic signed [31:0] est_three;
	logic signed [31:0] est_four;
	logic signed [31:0] est_five;
	logic cfg_write_en = 1'b0;
	logic [30:0] cfg_write_data = '0;

	// observer model
	longint cf_a [6][6];
	longint cf_b [6][2];
	longint cf_l [6][2];
	longint cf_c [2][6];
	longint est_model [6];
	logic [30:0] scale_model = 31'd468582;

	est_set_t pending_est [$];
	string est_names [6] = '{"est_zero", "est_one", "est_two", "est_three", "est_four",
		"est_five"};

	int errors = 0;
	int cycles = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	luenberger_observer_step DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.reading_first(reading_first),
		.reading_second(reading_second),
		.drive_first(drive_first),
		.drive_second(drive_second),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.est_zero(est_zero),
		.est_one(est_one),
		.est_two(est_two),
		.est_three(est_three),
		.est_four(est_four),
		.est_five(est_five),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	always #2 clk = ~clk;

	// decimal in units of 1e-10 to Q16.16, half away from zero
	function automatic longint q16_from_dec(input longint dec);
		longint mag;
		longint whole;
		longint rem;
		longint res;
		mag = (dec < 0) ? -dec : dec;
		whole = mag / DEC_UNIT;
		rem = mag % DEC_UNIT;
		res = (whole <<< FRAC) + ((rem <<< FRAC) + DEC_UNIT / 2) / DEC_UNIT;
		return (dec < 0) ? -res : res;
	endfunction

	function automatic longint clip32(input longint v);
		longint r;
		r = v;
		if (v > 64'sd2147483647) begin
			r = 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			r = -64'sd2147483648;
		end
		return r;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic est_set_t observe_step(input logic signed [31:0] r0,
		input logic signed [31:0] r1, input logic signed [31:0] d0, input logic signed [31:0] d1);
		longint meas [2];
		longint drv [2];
		longint innov [2];
		longint nxt [6];
		longint acc;
		longint a1;
		longint a2;
		longint a3;
		est_set_t res;
		meas[0] = clip32(qmul(longint'(r0), longint'(scale_model)));
		meas[1] = clip32(qmul(longint'(r1), longint'(scale_model)));
		drv[0] = longint'(d0);
		drv[1] = longint'(d1);
		for (int k = 0; k < 2; k++) begin
			acc = 0;
			for (int i = 0; i < 6; i++) begin
				acc += qmul(cf_c[k][i], est_model[i]);
			end
			innov[k] = clip32(clip32(acc) - meas[k]);
		end
		for (int i = 0; i < 6; i++) begin
			a1 = 0;
			a2 = 0;
			a3 = 0;
			for (int k = 0; k < 6; k++) begin
				a1 += qmul(cf_a[i][k], est_model[k]);
			end
			for (int k = 0; k < 2; k++) begin
				a2 += qmul(cf_b[i][k], drv[k]);
				a3 += qmul(cf_l[i][k], innov[k]);
			end
			nxt[i] = clip32(clip32(a1) + clip32(a2) - clip32(a3));
		end
		for (int i = 0; i < 6; i++) begin
			est_model[i] = nxt[i];
			res[i] = nxt[i][31:0];
		end
		return res;
	endfunction

	initial begin
		for (int i = 0; i < 6; i++) begin
			est_model[i] = 0;
			for (int k = 0; k < 6; k++) begin
				cf_a[i][k] = 0;
			end
			for (int k = 0; k < 2; k++) begin
				cf_b[i][k] = 0;
				cf_l[i][k] = 0;
				cf_c[k][i] = 0;
			end
		end
		cf_a[0][0] = q16_from_dec(64'sd6689870000);
		cf_a[0][2] = q16_from_dec(64'sd4370010000);
		cf_a[1][1] = q16_from_dec(64'sd7119520000);
		cf_a[1][3] = q16_from_dec(64'sd6253290000);
		cf_a[2][2] = q16_from_dec(64'sd4551890000);
		cf_a[3][3] = q16_from_dec(64'sd2320650000);
		cf_a[4][4] = q16_from_dec(64'sd10000000000);
		cf_a[5][5] = q16_from_dec(64'sd10000000000);
		cf_b[0][0] = q16_from_dec(64'sd5603500000);
		cf_b[0][1] = q16_from_dec(64'sd1026587000);
		cf_b[1][0] = q16_from_dec(64'sd1606720000);
		cf_b[1][1] = q16_from_dec(64'sd5769560000);
		cf_b[2][1] = q16_from_dec(64'sd2649723000);
		cf_b[3][0] = q16_from_dec(64'sd2012360000);
		cf_l[0][0] = q16_from_dec(-64'sd86550000);
		cf_l[1][1] = q16_from_dec(-64'sd630836400);
		cf_l[2][0] = q16_from_dec(-64'sd7020000);
		cf_l[3][1] = q16_from_dec(-64'sd8309694);
		cf_l[4][0] = q16_from_dec(64'sd7763130000);
		cf_l[5][1] = q16_from_dec(64'sd14240400000);
		cf_c[0][0] = q16_from_dec(64'sd60240960000);
		cf_c[0][4] = q16_from_dec(64'sd10000000000);
		cf_c[1][1] = q16_from_dec(64'sd60240960000);
		cf_c[1][5] = q16_from_dec(64'sd10000000000);
	end

	// scoreboard: model update on accepted transactions and config writes, result check
	always @(posedge clk) begin
		est_set_t got;
		est_set_t want;
		if (arst_n) begin
			if (cfg_write_en) begin
				scale_model = cfg_write_data;
			end
			if (in_valid && !in_stall) begin
				pending_est.push_back(observe_step(reading_first, reading_second, drive_first,
					drive_second));
			end
			if (out_valid && !out_stall) begin
				got = {est_five, est_four, est_three, est_two, est_one, est_zero};
				if (pending_est.size() == 0) begin
					$error("result transaction with no pending estimate");
					errors++;
				end else begin
					want = pending_est.pop_front();
					for (int i = 0; i < 6; i++) begin
						if (got[i] !== want[i]) begin
							$error("%s: expected %0d, actual %0d", est_names[i],
								$signed(want[i]), $signed(got[i]));
							errors++;
						end
					end
				end
			end
		end
	end

	// output side stall, random, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = HOLD_LEN;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic send_obs(input logic signed [31:0] r0, input logic signed [31:0] r1,
		input logic signed [31:0] d0, input logic signed [31:0] d1);
		int gap;
		if ($urandom_range(99) < send_pct) begin
			gap = ($urandom_range(9) == 0) ? $urandom_range(10, 120) : $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		reading_first <= r0;
		reading_second <= r1;
		drive_first <= d0;
		drive_second <= d1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_est.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_scale(input logic [30:0] v);
		drain();
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_word();
		logic signed [31:0] w;
		case ($urandom_range(9))
			0: begin
				w = $urandom;
			end
			1: begin
				case ($urandom_range(4))
					0: w = 32'sh7FFF_FFFF;
					1: w = 32'sh8000_0000;
					2: w = '0;
					3: w = -32'sd1;
					default: w = 32'sd1;
				endcase
			end
			default: begin
				w = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
			end
		endcase
		return w;
	endfunction

	function automatic logic [30:0] rand_scale();
		logic [30:0] s;
		case ($urandom_range(5))
			0: s = '0;
			1: s = '1;
			2: s = 31'($urandom);
			default: s = 31'($urandom_range(32'h0014_0000));
		endcase
		return s;
	endfunction

	task automatic test_default_scale();
		send_obs(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_obs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd0, 32'sd0);
		send_obs(32'sh8000_0000, 32'sh8000_0000, 32'sd0, 32'sd0);
		send_obs(32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_obs(32'sd0, 32'sd0, 32'sh8000_0000, 32'sh8000_0000);
		send_obs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_obs(-32'sd1, 32'sd1, 32'sd65536, -32'sd65536);
		send_obs(32'sd65536, 32'sd131072, 32'sd32768, -32'sd98304);
	endtask

	task automatic test_scale_extremes();
		write_scale('0);
		send_obs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd65536, 32'sd65536);
		send_obs(32'sd123456, -32'sd654321, 32'sd0, 32'sd0);
		send_obs(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		write_scale('1);
		send_obs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd0, 32'sd0);
		send_obs(32'sh8000_0000, 32'sh8000_0000, 32'sd0, 32'sd0);
		send_obs(32'sd1, -32'sd1, 32'sd0, 32'sd0);
		send_obs(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		write_scale(31'd65536);
		send_obs(32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536);
		send_obs(32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_obs(32'sd0, 32'sd0, 32'sd0, 32'sd0);
	endtask

	task automatic test_backpressure();
		send_pct = 0;
		recv_pct = 0;
		write_scale(31'd468582);
		hold_req = 1;
		repeat (8) begin
			send_obs(rand_word(), rand_word(), rand_word(), rand_word());
		end
		drain();
	endtask

	task automatic test_random_phase(input int s_pct, input int r_pct, input int n_items);
		send_pct = s_pct;
		recv_pct = r_pct;
		for (int c = 0; c < 6; c++) begin
			write_scale(rand_scale());
			for (int n = 0; n < n_items / 6; n++) begin
				send_obs(rand_word(), rand_word(), rand_word(), rand_word());
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_scale();
		test_scale_extremes();
		test_backpressure();
		test_random_phase(10, 64, 600);
		test_random_phase(64, 10, 600);
		test_random_phase(0, 0, 600);
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

@@ luenberger_observer_step.f @@
src/lobs_pkg.sv
src/lobs_ctrl.sv
src/lobs_dp.sv
src/luenberger_observer_step.sv
verif/tb_top.sv
